@@ sv/paar_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package paar_pkg;

    // Field widths of the transaction and configuration ports
    localparam int FUNC_W    = 2;
    localparam int SET_IDX_W = 6;
    localparam int WAY_IDX_W = 3;
    localparam int AGE_W     = 6;
    localparam int QUOTA_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_INVALIDATE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TOUCH      = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FILL       = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_VICTIM     = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_MAX        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESERVE_QUOTA = 2'd1;

    // Reset values of the configuration registers
    localparam logic [AGE_W-1:0]   AGE_MAX_RST = 6'd32;
    localparam logic [QUOTA_W-1:0] QUOTA_RST   = 4'd4;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

`default_nettype wire

@@ sv/preserve_aware_age_replacement_core.sv @@
// An accepted transaction reads its set row into registers; its result is then registered on m_*.
// Each op reads its set row from the state memories (registered read), then, unless it is
//   a victim search, modifies and writes it back; no new op is taken until the write-back.
// A result waiting on m_* stalls the write-back only while it is still not taken.
// Reset: synchronous, active low; afterwards a clearing pass zeroes every set row in turn,
//   and s_ready stays low until it ends (cfg writes are taken).
`timescale 1ns / 1ps
`default_nettype none

module preserve_aware_age_replacement_core #(
    parameter int WAYS = 8,
    parameter int SETS = 64
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,

    // operation transactions
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire  [paar_pkg::FUNC_W-1:0]         s_func,
    input  wire  [paar_pkg::SET_IDX_W-1:0]      s_set_index,
    input  wire  [paar_pkg::WAY_IDX_W-1:0]      s_way_index,
    input  wire                                 s_preserve_flag,

    // result transactions
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [paar_pkg::WAY_IDX_W-1:0]      m_victim_way,
    output logic                                m_victim_invalid,
    output logic                                m_victim_preserved,

    // configuration writes
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [paar_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [paar_pkg::CFG_DAT_W-1:0]      cfg_data
);

    localparam int AGE_W  = paar_pkg::AGE_W;
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_AW = $clog2(WAYS);
    localparam int TREE_P = 1 << WAY_AW;
    localparam int NODES  = 2 * TREE_P - 1;
    localparam int CNT_W  = $clog2(WAYS + 1);

    typedef logic [WAYS-1:0][AGE_W-1:0] age_row_t;
    typedef logic [WAYS-1:0]            pres_row_t;

    // ------------------------------------------------------------------
    // Configuration registers; always ready, unknown indexes are dropped
    // ------------------------------------------------------------------
    logic [AGE_W-1:0]             age_max_reg;
    logic [paar_pkg::QUOTA_W-1:0] quota_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            age_max_reg <= paar_pkg::AGE_MAX_RST;
            quota_reg   <= paar_pkg::QUOTA_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                paar_pkg::CFG_AGE_MAX:        age_max_reg <= cfg_data[AGE_W-1:0];
                paar_pkg::CFG_PRESERVE_QUOTA: quota_reg   <= cfg_data[paar_pkg::QUOTA_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    paar_pkg::state_t state_reg, state_next;
    logic [SET_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             m_valid_reg;
    logic             s_fire;
    logic             exec_go;
    logic             clr_last;

    assign s_fire   = s_valid && s_ready;
    assign clr_last = (clr_cnt_reg == SET_W'(SETS - 1));

    // Write back only when the output register can take the result
    assign exec_go = (state_reg == paar_pkg::ST_EXEC) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= paar_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        s_ready      = 1'b0;
        case (state_reg)
            paar_pkg::ST_CLEAR: begin
                // sweep one set row per cycle
                clr_cnt_next = clr_cnt_reg + SET_W'(1);
                if (clr_last) begin
                    state_next   = paar_pkg::ST_IDLE;
                    clr_cnt_next = '0;
                end
            end
            paar_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = paar_pkg::ST_EXEC;
                end
            end
            paar_pkg::ST_EXEC: begin
                if (exec_go) begin
                    state_next = paar_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = paar_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Capture the operation at acceptance
    // ------------------------------------------------------------------
    logic [SET_W+paar_pkg::SET_IDX_W-1:0] set_ext;
    logic [SET_W-1:0]                     rd_addr;
    logic [WAY_AW+paar_pkg::WAY_IDX_W-1:0] way_ext;

    assign set_ext = {{SET_W{1'b0}}, s_set_index};
    assign rd_addr = set_ext[SET_W-1:0];
    assign way_ext = {{WAY_AW{1'b0}}, s_way_index};

    logic [paar_pkg::FUNC_W-1:0] func_reg;
    logic [SET_W-1:0]            set_reg;
    logic                        set_ok_reg;
    logic [WAY_AW-1:0]           way_reg;
    logic                        way_ok_reg;
    logic                        pbit_reg;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            func_reg   <= s_func;
            set_reg    <= rd_addr;
            set_ok_reg <= (32'(s_set_index) < SETS);
            way_reg    <= way_ext[WAY_AW-1:0];
            way_ok_reg <= (32'(s_way_index) < WAYS);
            pbit_reg   <= s_preserve_flag;
        end
    end

    // ------------------------------------------------------------------
    // State memories: one row per set, registered read, one write port
    // ------------------------------------------------------------------
    age_row_t  mem_age  [SETS];
    pres_row_t mem_pres [SETS];
    age_row_t  age_rd_reg;
    pres_row_t pres_rd_reg;

    logic             mem_we;
    logic [SET_W-1:0] mem_waddr;
    age_row_t         mem_wage;
    pres_row_t        mem_wpres;
    age_row_t         upd_age;
    pres_row_t        upd_pres;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_age[mem_waddr]  <= mem_wage;
            mem_pres[mem_waddr] <= mem_wpres;
        end
        if (s_fire) begin
            age_rd_reg  <= mem_age[rd_addr];
            pres_rd_reg <= mem_pres[rd_addr];
        end
    end

    // Clearing pass owns the write port until it ends
    always_comb begin
        if (state_reg == paar_pkg::ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wage  = '0;
            mem_wpres = '0;
        end else begin
            mem_we    = exec_go && set_ok_reg && way_ok_reg
                        && (func_reg != paar_pkg::FUNC_VICTIM);
            mem_waddr = set_reg;
            mem_wage  = upd_age;
            mem_wpres = upd_pres;
        end
    end

    // ------------------------------------------------------------------
    // Row update: invalidate, touch, fill (ages the filled line's class)
    // ------------------------------------------------------------------
    always_comb begin
        upd_age  = age_rd_reg;
        upd_pres = pres_rd_reg;
        case (func_reg)
            paar_pkg::FUNC_INVALIDATE: begin
                upd_age[way_reg] = '0;
            end
            paar_pkg::FUNC_TOUCH: begin
                upd_age[way_reg] = age_max_reg;
            end
            paar_pkg::FUNC_FILL: begin
                upd_pres[way_reg] = pbit_reg;
                for (int w = 0; w < WAYS; w++) begin
                    if ((upd_pres[w] == pbit_reg) && (age_rd_reg[w] > AGE_W'(1))) begin
                        upd_age[w] = age_rd_reg[w] - AGE_W'(1);
                    end
                end
                upd_age[way_reg] = age_max_reg;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Victim search
    // ------------------------------------------------------------------

    // Oldest way of one preserve class as a compare tree; the left child
    // wins ties, so the lower way is picked.
    function automatic logic [WAY_AW-1:0] oldest_in_class(
        input age_row_t  ages,
        input pres_row_t pres,
        input logic      cls
    );
        logic [AGE_W:0]    key [NODES];
        logic [WAY_AW-1:0] idx [NODES];
        for (int i = 0; i < TREE_P; i++) begin
            if (i < WAYS) begin
                key[TREE_P-1+i] = {pres[i] != cls, ages[i]};
            end else begin
                key[TREE_P-1+i] = '1;
            end
            idx[TREE_P-1+i] = WAY_AW'(i);
        end
        for (int n = TREE_P - 2; n >= 0; n--) begin
            if (key[2*n+1] <= key[2*n+2]) begin
                key[n] = key[2*n+1];
                idx[n] = idx[2*n+1];
            end else begin
                key[n] = key[2*n+2];
                idx[n] = idx[2*n+2];
            end
        end
        return idx[0];
    endfunction

    logic              inv_any;
    logic [WAY_AW-1:0] inv_idx;
    logic [CNT_W-1:0]  pres_cnt;
    logic              unp_any;
    logic [WAY_AW-1:0] pres_old;
    logic [WAY_AW-1:0] unp_old;
    logic [WAY_AW-1:0] pick;
    logic              pick_pres;
    logic [WAY_AW+paar_pkg::WAY_IDX_W-1:0] pick_ext;

    always_comb begin
        inv_any = 1'b0;
        inv_idx = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (age_rd_reg[i] == '0) begin
                inv_any = 1'b1;
                inv_idx = WAY_AW'(i);
            end
        end
    end

    assign pres_cnt = CNT_W'($countones(pres_rd_reg));
    assign unp_any  = |(~pres_rd_reg);
    assign pres_old = oldest_in_class(age_rd_reg, pres_rd_reg, 1'b1);
    assign unp_old  = oldest_in_class(age_rd_reg, pres_rd_reg, 1'b0);

    always_comb begin
        if (inv_any) begin
            pick = inv_idx;
        end else if (32'(pres_cnt) > 32'(quota_reg)) begin
            pick = pres_old;
        end else if (unp_any) begin
            pick = unp_old;
        end else begin
            pick = '0;
        end
    end

    assign pick_pres = inv_any ? 1'b0 : pres_rd_reg[pick];
    assign pick_ext  = {{paar_pkg::WAY_IDX_W{1'b0}}, pick};

    // ------------------------------------------------------------------
    // Output register; non-victim and out-of-range ops report all zero
    // ------------------------------------------------------------------
    logic [paar_pkg::WAY_IDX_W-1:0] victim_way_reg;
    logic                           victim_invalid_reg;
    logic                           victim_preserved_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (exec_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_go) begin
            if (set_ok_reg && (func_reg == paar_pkg::FUNC_VICTIM)) begin
                victim_way_reg       <= pick_ext[paar_pkg::WAY_IDX_W-1:0];
                victim_invalid_reg   <= inv_any;
                victim_preserved_reg <= pick_pres;
            end else begin
                victim_way_reg       <= '0;
                victim_invalid_reg   <= 1'b0;
                victim_preserved_reg <= 1'b0;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_victim_way       = victim_way_reg;
    assign m_victim_invalid   = victim_invalid_reg;
    assign m_victim_preserved = victim_preserved_reg;

endmodule

`default_nettype wire

@@ sv/paar_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module paar_checker (
    input wire                              aclk,
    input wire                              aresetn,
    input wire                              s_valid,
    input wire                              s_ready,
    input wire                              m_valid,
    input wire                              m_ready,
    input wire [paar_pkg::WAY_IDX_W-1:0]    m_victim_way,
    input wire                              m_victim_invalid,
    input wire                              m_victim_preserved
);

    // one op in flight: no back-to-back acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("transaction accepted while previous op still executing");

    // an invalid victim never reports the preserved class
    a_invalid_not_preserved: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_victim_invalid) |-> !m_victim_preserved)
        else $error("invalid victim flagged as preserved");

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_victim_way)
            && $stable(m_victim_invalid) && $stable(m_victim_preserved)))
        else $error("stalled result changed");

endmodule

bind preserve_aware_age_replacement_core paar_checker u_paar_checker (.*);

`default_nettype wire
